/* hw/rtl/rpn_pkg.sv */
// shared types and constants for the postfix stack calculator
// token kinds, result codes, controller states and the command/status bundles
// no dependencies
package rpn_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int OPND_W      = 31;
   localparam int STEP_W      = $clog2(DATA_W);

   typedef enum logic [2:0] {
      KIND_PUSH = 3'd0,
      KIND_NEG  = 3'd1,
      KIND_ADD  = 3'd2,
      KIND_SUB  = 3'd3,
      KIND_MUL  = 3'd4,
      KIND_DIV  = 3'd5,
      KIND_MOD  = 3'd6,
      KIND_END  = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_UNDER    = 3'd1,
      ST_LEFTOVER = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_TAKE_B,
      S_TAKE_A,
      S_EXEC,
      S_DIVIDE,
      S_WRITE,
      S_EMIT
   } state_type;

   // stack address: slot at count, top of stack, entry below the top
   typedef enum logic [1:0] {
      AS_COUNT,
      AS_TOP,
      AS_SECOND
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_PUSH,
      WD_NEG,
      WD_RES
   } wd_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLR
   } cnt_op_type;

   typedef struct packed {
      logic         capture;
      logic         mem_rd;
      addr_sel_type rd_sel;
      logic         mem_wr;
      addr_sel_type wr_sel;
      wd_sel_type   wd_sel;
      cnt_op_type   cnt_op;
      logic         load_b;
      logic         load_a;
      logic         load_ans;
      logic         alu_load;
      logic         div_start;
      logic         div_load;
      kind_type     op;
      logic         emit;
      status_type   emit_code;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_one;
      logic cnt_lt2;
      logic cnt_full;
      logic b_zero;
      logic div_done;
      logic out_busy;
   } sts_type;

endpackage

/* hw/rtl/rpn_div.sv */
// unsigned 32-bit restoring divider, one quotient bit per cycle
// depends on rpn_pkg
module rpn_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpn_pkg::DATA_W-1:0] dividend,
   input  logic [rpn_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [rpn_pkg::DATA_W-1:0] quotient,
   output logic [rpn_pkg::DATA_W-1:0] remainder
);
   import rpn_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   // one restoring step: shift in next dividend bit, subtract if it fits
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // completion only follows a running division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

/* hw/rtl/rpn_dpath.sv */
// datapath: operand stack memory, count, operand registers, alu, divider,
// result register; depends on rpn_pkg and rpn_div
module rpn_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  rpn_pkg::cmd_type           cmd,
   output rpn_pkg::sts_type           sts,
   input  logic [rpn_pkg::OPND_W-1:0] req_operand_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [rpn_pkg::DATA_W-1:0] rsp_answer,
   output logic [2:0]                 rsp_status
);
   import rpn_pkg::*;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [OPND_W-1:0] opnd_ff;
   logic [DATA_W-1:0] a_ff, b_ff, ans_ff, res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_answer_ff;
   status_type        rsp_status_ff;
   logic [PTR_W-1:0]  at_count, at_top, at_second, rd_addr, wr_addr;
   logic [DATA_W-1:0] wdata, alu_res, div_res;
   logic [DATA_W-1:0] mag_a, mag_b, quo, rem;
   logic              div_done;

   // stack addresses
   assign at_count  = count_ff[PTR_W-1:0];
   assign at_top    = PTR_W'(count_ff - CNT_W'(1));
   assign at_second = PTR_W'(count_ff - CNT_W'(2));

   always_comb begin
      unique case (cmd.rd_sel)
         AS_COUNT:  rd_addr = at_count;
         AS_TOP:    rd_addr = at_top;
         AS_SECOND: rd_addr = at_second;
         default:   rd_addr = at_top;
      endcase
      unique case (cmd.wr_sel)
         AS_COUNT:  wr_addr = at_count;
         AS_TOP:    wr_addr = at_top;
         AS_SECOND: wr_addr = at_second;
         default:   wr_addr = at_second;
      endcase
      unique case (cmd.wd_sel)
         WD_PUSH: wdata = {1'b0, opnd_ff};
         WD_NEG:  wdata = '0 - rdata_ff;
         WD_RES:  wdata = res_ff;
         default: wdata = res_ff;
      endcase
   end

   // operand stack memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         stack_mem[wr_addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= stack_mem[rd_addr];
      end
   end

   // operand count
   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_ff - CNT_W'(1);
         CNT_CLR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   // add, sub and mul on the registered operands
   always_comb begin
      case (cmd.op)
         KIND_SUB: alu_res = a_ff - b_ff;
         KIND_MUL: alu_res = a_ff * b_ff;
         default:  alu_res = a_ff + b_ff;
      endcase
   end

   // signed division through magnitudes, sign fixed afterward
   assign mag_a = a_ff[DATA_W-1] ? ('0 - a_ff) : a_ff;
   assign mag_b = b_ff[DATA_W-1] ? ('0 - b_ff) : b_ff;

   rpn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   always_comb begin
      if (cmd.op == KIND_MOD) begin
         div_res = a_ff[DATA_W-1] ? ('0 - rem) : rem;
      end else begin
         div_res = (a_ff[DATA_W-1] ^ b_ff[DATA_W-1]) ? ('0 - quo) : quo;
      end
      res_in = res_ff;
      if (cmd.alu_load) begin
         res_in = alu_res;
      end else if (cmd.div_load) begin
         res_in = div_res;
      end
   end

   // result register toward the requester
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opnd_ff <= req_operand_value;
      end
      if (cmd.load_b) begin
         b_ff <= rdata_ff;
      end
      if (cmd.load_a) begin
         a_ff <= rdata_ff;
      end
      if (cmd.load_ans) begin
         ans_ff <= rdata_ff;
      end
      res_ff <= res_in;
      if (cmd.emit) begin
         rsp_answer_ff <= (cmd.emit_code == ST_OK) ? ans_ff : '0;
         rsp_status_ff <= cmd.emit_code;
      end
   end

   // status toward the controller
   always_comb begin
      sts.cnt_zero = (count_ff == '0);
      sts.cnt_one  = (count_ff == CNT_W'(1));
      sts.cnt_lt2  = (count_ff < CNT_W'(2));
      sts.cnt_full = (count_ff >= CNT_W'(STACK_DEPTH));
      sts.b_zero   = (b_ff == '0);
      sts.div_done = div_done;
      sts.out_busy = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("operand count beyond stack depth");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> count_ff == '0)
      else $error("stack not cleared after result");

endmodule

/* hw/rtl/rpn_ctrl.sv */
// controller state machine for the postfix stack calculator
// sequences stack reads, writes, alu and divider; depends on rpn_pkg
module rpn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_kind,
   input  rpn_pkg::sts_type      sts,
   output rpn_pkg::cmd_type      cmd
);
   import rpn_pkg::*;

   state_type  state_ff, state_in;
   kind_type   kind_ff, kind_in;
   status_type code_ff, code_in;
   logic       is_div;

   assign is_div = (kind_ff == KIND_DIV) || (kind_ff == KIND_MOD);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      code_in       = code_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.rd_sel    = AS_TOP;
      cmd.wr_sel    = AS_SECOND;
      cmd.wd_sel    = WD_RES;
      cmd.cnt_op    = CNT_HOLD;
      cmd.op        = kind_ff;
      cmd.emit_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               kind_in     = kind_type'(req_kind);
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (kind_ff)
               KIND_PUSH: begin
                  if (sts.cnt_full) begin
                     code_in  = ST_FULL;
                     state_in = S_EMIT;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wr_sel = AS_COUNT;
                     cmd.wd_sel = WD_PUSH;
                     cmd.cnt_op = CNT_INC;
                     state_in   = S_IDLE;
                  end
               end
               KIND_NEG: begin
                  if (sts.cnt_zero) begin
                     code_in  = ST_UNDER;
                     state_in = S_EMIT;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_TAKE_B;
                  end
               end
               KIND_END: begin
                  if (sts.cnt_zero) begin
                     code_in  = ST_UNDER;
                     state_in = S_EMIT;
                  end else if (!sts.cnt_one) begin
                     code_in  = ST_LEFTOVER;
                     state_in = S_EMIT;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_TAKE_B;
                  end
               end
               default: begin
                  if (sts.cnt_lt2) begin
                     code_in  = ST_UNDER;
                     state_in = S_EMIT;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_TAKE_B;
                  end
               end
            endcase
         end
         S_TAKE_B: begin
            cmd.load_b = 1'b1;
            if (kind_ff == KIND_NEG) begin
               cmd.mem_wr = 1'b1;
               cmd.wr_sel = AS_TOP;
               cmd.wd_sel = WD_NEG;
               state_in   = S_IDLE;
            end else if (kind_ff == KIND_END) begin
               cmd.load_ans = 1'b1;
               code_in      = ST_OK;
               state_in     = S_EMIT;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = AS_SECOND;
               state_in   = S_TAKE_A;
            end
         end
         S_TAKE_A: begin
            cmd.load_a = 1'b1;
            if (is_div && sts.b_zero) begin
               code_in  = ST_DIVZERO;
               state_in = S_EMIT;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (is_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end else begin
               cmd.alu_load = 1'b1;
               state_in     = S_WRITE;
            end
         end
         S_DIVIDE: begin
            if (sts.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = AS_SECOND;
            cmd.wd_sel = WD_RES;
            cmd.cnt_op = CNT_DEC;
            state_in   = S_IDLE;
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit   = 1'b1;
               cmd.cnt_op = CNT_CLR;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request kind and pending result code
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      code_ff <= code_in;
   end

   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE)
      else $error("controller did not return to idle after result");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == S_DIVIDE)
      else $error("divider started outside divide sequence");

endmodule

/* hw/rtl/rpn_stack_calculator.sv */
// top level of the postfix stack calculator
// joins controller rpn_ctrl and datapath rpn_dpath; depends on rpn_pkg
//
// usage: each request is one postfix token (push, negate, add, sub, mul,
// div, mod, end) on the req_ channel with valid/ready. A response appears
// on the rsp_ channel only for end or an error: answer plus status
// (ok, underflow, leftover operands, divide by zero, stack full). After a
// response the operand stack is empty.
// each request runs through controller states from accept until ready is
// raised again; errors and end results leave through the response register.
// div and mod wait in S_DIVIDE for the divider, which forms one quotient
// bit per cycle over 32 bits. One request is in work at a time.
// the stack lives in a 64-entry memory with one read and one write port and
// registered read data, read once per operand.
// reset empties the stack and drops any pending response; the memory needs
// no clearing pass. If the receiver stalls, the response is held in its
// register and the next request is still taken; only a second response
// waits until the first one is taken.
module rpn_stack_calculator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_kind,
   input  logic [rpn_pkg::OPND_W-1:0]        req_operand_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rpn_pkg::DATA_W-1:0] rsp_answer,
   output logic [2:0]                        rsp_status
);
   import rpn_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack, arithmetic and response register
   rpn_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_answer        (rsp_answer),
      .rsp_status        (rsp_status)
   );

endmodule
